/* hdl/fomps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomps_pkg: shared types and codes of the FIFO-or-max priority server
// Transaction structs, opcode and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package fomps_pkg;

  localparam int unsigned CapacityDef      = 64;
  localparam int unsigned PriorityWidthDef = 16;

  // opcodes; anything with the high bit set serves highest priority
  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_OLDEST = 2'd1;

  // result status codes
  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_SERVED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] served_id;
  } out_item_t;

  // source of the served id in a result
  typedef enum logic [1:0] {
    ID_ZERO,
    ID_RD,
    ID_BEST
  } id_src_e;

  typedef struct packed {
    logic       latch_in;
    logic       probe_init;
    logic       probe_step;
    logic       do_store;
    logic       scan_clear;
    logic       scan_run;
    logic       scan_max;
    logic       remove;
    logic       remove_best;
    logic       set_oldest;
    logic       res_load;
    logic [1:0] res_status;
    id_src_e    res_id;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       full;
    logic       empty;
    logic       probe_free;
    logic       scan_done;
    logic       out_busy;
  } dp_stat_t;

endpackage

/* hdl/fomps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomps_ctrl: sequencer of the priority server
// One-hot state machine that steps the datapath through each transaction.
// ----------------------------------------------------------------------------
module fomps_ctrl import fomps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_FIND    = 8'b0000_0100,
    S_MAXSCAN = 8'b0000_1000,
    S_RMMAX   = 8'b0001_0000,
    S_RMOLD   = 8'b0010_0000,
    S_REFRESH = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_id = ID_ZERO;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.opcode)
          OP_ARRIVE: begin
            if (stat_i.full) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_FULL;
              state_d          = S_RESP;
            end else begin
              cmd_o.probe_init = 1'b1;
              state_d          = S_FIND;
            end
          end
          OP_OLDEST: begin
            if (stat_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_RESP;
            end else begin
              // memory read port sits on the oldest slot while not scanning
              state_d = S_RMOLD;
            end
          end
          default: begin
            if (stat_i.empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_RESP;
            end else begin
              cmd_o.scan_clear = 1'b1;
              state_d          = S_MAXSCAN;
            end
          end
        endcase
      end
      S_FIND: begin
        if (stat_i.probe_free) begin
          cmd_o.do_store   = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_STORED;
          cmd_o.scan_clear = 1'b1;
          state_d          = S_REFRESH;
        end else begin
          cmd_o.probe_step = 1'b1;
        end
      end
      S_MAXSCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.scan_max = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_RMMAX;
        end
      end
      S_RMMAX: begin
        cmd_o.remove      = 1'b1;
        cmd_o.remove_best = 1'b1;
        cmd_o.res_load    = 1'b1;
        cmd_o.res_status  = ST_SERVED;
        cmd_o.res_id      = ID_BEST;
        cmd_o.scan_clear  = 1'b1;
        state_d           = S_REFRESH;
      end
      S_RMOLD: begin
        cmd_o.remove     = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_SERVED;
        cmd_o.res_id     = ID_RD;
        cmd_o.scan_clear = 1'b1;
        state_d          = S_REFRESH;
      end
      S_REFRESH: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.set_oldest = 1'b1;
          state_d          = S_RESP;
        end
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/fomps_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fomps_dpath: entry store and scan unit of the priority server
// Priority/id memories, valid bits, free-slot probe, one-entry-per-cycle scan
// for the oldest or highest entry, and the output register.
// ----------------------------------------------------------------------------
module fomps_dpath import fomps_pkg::*; #(
  parameter int unsigned CAPACITY       = CapacityDef,
  parameter int unsigned PRIORITY_WIDTH = PriorityWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  logic [PRIORITY_WIDTH-1:0] pri_mem [CAPACITY];
  logic [31:0]               id_mem  [CAPACITY];

  logic [CAPACITY-1:0]       valid_q;
  logic [1:0]                opcode_q;
  logic [PRIORITY_WIDTH-1:0] pri_q;
  logic [AW-1:0]             oldest_q, next_slot_q, probe_q;
  logic [CW-1:0]             count_q, scan_q;
  logic [31:0]               next_id_q;

  logic [AW-1:0]             rd_addr, rd_slot_q;
  logic [31:0]               rd_id_q;
  logic [PRIORITY_WIDTH-1:0] rd_pri_q;
  logic                      rd_vld_q, rd_act_q;

  logic                      found_q;
  logic [AW-1:0]             best_slot_q;
  logic [31:0]               best_age_q, best_id_q;
  logic [PRIORITY_WIDTH-1:0] best_pri_q;

  logic [1:0]                res_status_q;
  logic [31:0]               res_id_q;
  logic                      out_valid_q;
  out_item_t                 out_data_q;

  logic [31:0]               pri_ext;
  logic [AW-1:0]             probe_inc, rm_slot;
  logic                      scan_issue, age_gt, better, take;
  logic [31:0]               cand_age;

  assign pri_ext    = {16'd0, in_data_i.priority_req};
  assign probe_inc  = (probe_q == LastSlot) ? '0 : probe_q + AW'(1);
  assign rm_slot    = cmd_i.remove_best ? best_slot_q : oldest_q;
  assign scan_issue = cmd_i.scan_run && (scan_q < CapCount);
  assign rd_addr    = scan_issue ? scan_q[AW-1:0] : oldest_q;

  // age relative to the next id, modulo 2^32
  assign cand_age = next_id_q - rd_id_q;
  assign age_gt   = cand_age > best_age_q;
  assign better   = cmd_i.scan_max ?
                    ((rd_pri_q > best_pri_q) || ((rd_pri_q == best_pri_q) && age_gt)) :
                    age_gt;
  assign take     = cmd_i.scan_run && rd_act_q && rd_vld_q && (!found_q || better);

  // entry memories, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_store) begin
      pri_mem[probe_q] <= pri_q;
      id_mem[probe_q]  <= next_id_q;
    end
    rd_pri_q <= pri_mem[rd_addr];
    rd_id_q  <= id_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_slot_q <= rd_addr;
    rd_vld_q  <= valid_q[rd_addr];
    if (cmd_i.latch_in) begin
      opcode_q <= in_data_i.opcode;
      pri_q    <= pri_ext[PRIORITY_WIDTH-1:0];
    end
    if (take) begin
      best_slot_q <= rd_slot_q;
      best_age_q  <= cand_age;
      best_pri_q  <= rd_pri_q;
      best_id_q   <= rd_id_q;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      case (cmd_i.res_id)
        ID_RD:   res_id_q <= rd_id_q;
        ID_BEST: res_id_q <= best_id_q;
        default: res_id_q <= 32'd0;
      endcase
    end
    if (cmd_i.out_load) begin
      out_data_q.status    <= res_status_q;
      out_data_q.served_id <= res_id_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      oldest_q    <= '0;
      next_slot_q <= '0;
      probe_q     <= '0;
      count_q     <= '0;
      next_id_q   <= 32'd1;
      scan_q      <= '0;
      rd_act_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.probe_init) begin
        probe_q <= next_slot_q;
      end else if (cmd_i.probe_step) begin
        probe_q <= probe_inc;
      end
      if (cmd_i.do_store) begin
        valid_q[probe_q] <= 1'b1;
        next_slot_q      <= probe_inc;
        count_q          <= count_q + CW'(1);
        next_id_q        <= next_id_q + 32'd1;
      end
      if (cmd_i.remove) begin
        valid_q[rm_slot] <= 1'b0;
        count_q          <= count_q - CW'(1);
      end
      if (cmd_i.scan_clear) begin
        scan_q   <= '0;
        rd_act_q <= 1'b0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan_run) begin
        if (scan_issue) begin
          scan_q <= scan_q + CW'(1);
        end
        rd_act_q <= scan_issue;
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.set_oldest) begin
        oldest_q <= found_q ? best_slot_q : '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.opcode     = opcode_q;
  assign stat_o.full       = (count_q >= CapCount);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.probe_free = !valid_q[probe_q];
  assign stat_o.scan_done  = (scan_q == CapCount) && !rd_act_q;
  assign stat_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("occupied count out of step with valid bits");

  a_store_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_store |-> (!valid_q[probe_q] && (count_q < CapCount)))
    else $error("store into an occupied slot or a full store");

  a_remove_live_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.remove |-> valid_q[rm_slot])
    else $error("removal of an empty slot");

  a_oldest_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.set_oldest && (count_q != '0)) |-> (found_q && valid_q[best_slot_q]))
    else $error("refresh scan missed a waiting entry");

endmodule

/* hdl/fifo_or_max_priority_server_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_or_max_priority_server_unit: waiting store served oldest-first or
// highest-priority-first
// Request store of CAPACITY entries with per-arrival ids and two serve orders.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one opcode and a
// priority; output channel (out_valid_o / out_stall_i / out_data_o) returns
// one status and served id per input transaction, in order.
// One transaction is worked at a time; in_stall_o is low only while idle.
// Steps from accept to result, with a refresh scan of the single-port entry
// memories (one entry per cycle, in sequence) that finds the oldest slot:
//   serve on empty store, arrival on full store: result
//   arrival: free-slot probe, store, refresh scan, result
//   serve oldest: remove oldest, refresh scan, result
//   serve highest: max-priority scan, remove best, refresh scan, result
// The next transaction can be accepted once the result is loaded into the output register.
// The result sits in an output register; a new transaction is accepted while
// it waits, and a stalled receiver only holds the block at its final step.
// Reset empties the store and restarts ids at 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_or_max_priority_server_unit import fomps_pkg::*; #(
  parameter int unsigned CAPACITY       = CapacityDef,
  parameter int unsigned PRIORITY_WIDTH = PriorityWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fomps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fomps_dpath #(
    .CAPACITY       (CAPACITY),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
